[sv/packet_frame_builder_unit_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef PACKET_FRAME_BUILDER_UNIT_ASSERT_SVH
`define PACKET_FRAME_BUILDER_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define PFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfb assertion failed");

// Checked at every edge, reset included.
`define PFB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pfb assertion failed");

`endif

[sv/pfb_pkg.sv]
// ----------------------------------------------------------------------------
// pfb_pkg
// Types and constants of the packet frame builder.
// ----------------------------------------------------------------------------
package pfb_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_ACK     = 2'd2;

  // Command kinds passed from the front to the serializer.
  localparam logic [1:0] CMD_REJECT  = 2'd0;
  localparam logic [1:0] CMD_HEADER  = 2'd1;
  localparam logic [1:0] CMD_PAYLOAD = 2'd2;
  localparam logic [1:0] CMD_ACK     = 2'd3;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] ACK_LEN   = 8'd6;
  localparam logic [7:0] CHR_A     = 8'h61;
  localparam logic [7:0] CHR_C     = 8'h63;
  localparam logic [7:0] CHR_K     = 8'h6B;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_SEMI  = 8'h3B;
  // Sum of the fixed ack payload characters, modulo 256.
  localparam logic [7:0] ACK_CHAR_SUM = 8'(CHR_A + CHR_C + CHR_K + CHR_COLON + CHR_SEMI);

  // Index of the final byte of an ack frame.
  localparam logic [3:0] ACK_LAST_STEP = 4'd13;
  localparam logic [3:0] HDR_LAST_STEP = 4'd6;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] destination;
    logic [7:0] source;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic [7:0] acked_id;
  } pfb_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       rejected;
  } pfb_out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] id;
    logic [7:0] dst;
    logic [7:0] src;
    logic [7:0] dev;
    logic [7:0] len;
    logic [7:0] data;
    logic [7:0] csum;
    logic       has_csum;
  } pfb_cmd_t;

endpackage

[sv/pfb_if.sv]
// ----------------------------------------------------------------------------
// pfb_in_if / pfb_out_if
// Valid/ready channels carrying input items and output words.
// ----------------------------------------------------------------------------
interface pfb_in_if;
  import pfb_pkg::*;
  logic    valid;
  logic    ready;
  pfb_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfb_out_if;
  import pfb_pkg::*;
  logic     valid;
  logic     ready;
  pfb_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/pfb_front.sv]
// ----------------------------------------------------------------------------
// pfb_front
// Accepts items, checks ordering, tracks the open frame and the running
// checksum, and turns each item into one serializer command.
// ----------------------------------------------------------------------------
module pfb_front #(
  parameter int MAX_PAYLOAD = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  pfb_in_if.sink          in_ch,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            q_full,
  output logic            push,
  output pfb_pkg::pfb_cmd_t cmd
);
  import pfb_pkg::*;

  localparam int REM_W = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]       dev_id_r;
  logic [7:0]       frame_cnt_r, frame_cnt_nxt;
  logic [7:0]       run_sum_r, run_sum_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             open_r, open_nxt;
  logic [7:0]       sum;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    frame_cnt_nxt = frame_cnt_r;
    run_sum_nxt   = run_sum_r;
    rem_nxt       = rem_r;
    open_nxt      = open_r;
    sum           = 8'd0;
    cmd           = '0;
    cmd.id        = frame_cnt_r;
    cmd.dst       = in_ch.data.destination;
    cmd.src       = in_ch.data.source;
    cmd.dev       = dev_id_r;
    cmd.len       = in_ch.data.length;
    cmd.data      = in_ch.data.data_byte;
    cmd.kind      = CMD_REJECT;
    unique case (in_ch.data.op)
      OP_START: begin
        if (!open_r && in_ch.data.length <= 8'(MAX_PAYLOAD)) begin
          sum           = frame_cnt_r + in_ch.data.destination + in_ch.data.source
                          + dev_id_r + in_ch.data.length;
          cmd.kind      = CMD_HEADER;
          cmd.has_csum  = (in_ch.data.length == 8'd0);
          frame_cnt_nxt = frame_cnt_r + 8'd1;
          run_sum_nxt   = sum;
          rem_nxt       = in_ch.data.length[REM_W-1:0];
          open_nxt      = (in_ch.data.length != 8'd0);
        end
      end
      OP_PAYLOAD: begin
        if (open_r) begin
          sum          = run_sum_r + in_ch.data.data_byte;
          cmd.kind     = CMD_PAYLOAD;
          cmd.has_csum = (rem_r == REM_W'(1));
          run_sum_nxt  = sum;
          rem_nxt      = rem_r - REM_W'(1);
          open_nxt     = (rem_r != REM_W'(1));
        end
      end
      OP_ACK: begin
        if (!open_r) begin
          sum           = frame_cnt_r + in_ch.data.destination + dev_id_r + dev_id_r
                          + ACK_LEN + ACK_CHAR_SUM + in_ch.data.acked_id;
          cmd.kind      = CMD_ACK;
          cmd.src       = dev_id_r;
          cmd.len       = ACK_LEN;
          cmd.data      = in_ch.data.acked_id;
          cmd.has_csum  = 1'b1;
          frame_cnt_nxt = frame_cnt_r + 8'd1;
          run_sum_nxt   = sum;
        end
      end
      default: begin
        cmd.kind = CMD_REJECT;
      end
    endcase
    // 0xFF minus the sum is its bitwise complement.
    cmd.csum = ~sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r    <= 8'd0;
      frame_cnt_r <= 8'd0;
      run_sum_r   <= 8'd0;
      rem_r       <= '0;
      open_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        dev_id_r <= cfg_wdata;
      end
      if (push) begin
        frame_cnt_r <= frame_cnt_nxt;
        run_sum_r   <= run_sum_nxt;
        rem_r       <= rem_nxt;
        open_r      <= open_nxt;
      end
    end
  end

endmodule

[sv/pfb_queue.sv]
// ----------------------------------------------------------------------------
// pfb_queue
// Small first-in first-out queue of serializer commands.
// ----------------------------------------------------------------------------
module pfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfb_pkg::pfb_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output pfb_pkg::pfb_cmd_t head
);
  import pfb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pfb_cmd_t        entry_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

[sv/pfb_back.sv]
// ----------------------------------------------------------------------------
// pfb_back
// Serializer: expands the command at the queue head into frame words, one
// per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module pfb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pfb_pkg::pfb_cmd_t head,
  output logic              pop,
  pfb_out_if.source         out_ch
);
  import pfb_pkg::*;

  logic [3:0] step_r;
  logic [3:0] last_step;
  logic       load;
  logic       is_last;
  pfb_out_t   word;
  pfb_out_t   out_r;
  logic       out_valid_r;

  assign load    = q_valid && (!out_valid_r || out_ch.ready);
  assign is_last = (step_r == last_step);
  assign pop     = load && is_last;

  always_comb begin
    unique case (head.kind)
      CMD_REJECT:  last_step = 4'd0;
      CMD_PAYLOAD: last_step = head.has_csum ? 4'd1 : 4'd0;
      CMD_HEADER:  last_step = head.has_csum ? HDR_LAST_STEP + 4'd1 : HDR_LAST_STEP;
      default:     last_step = ACK_LAST_STEP;
    endcase
  end

  always_comb begin
    word          = '0;
    word.last     = is_last;
    word.rejected = (head.kind == CMD_REJECT);
    if (head.kind == CMD_PAYLOAD) begin
      word.tx_byte = step_r[0] ? head.csum : head.data;
    end else if (head.kind != CMD_REJECT) begin
      unique case (step_r) inside
        4'd0, 4'd1: word.tx_byte = SYNC_BYTE;
        4'd2:       word.tx_byte = head.id;
        4'd3:       word.tx_byte = head.dst;
        4'd4:       word.tx_byte = head.src;
        4'd5:       word.tx_byte = head.dev;
        4'd6:       word.tx_byte = head.len;
        4'd7:       word.tx_byte = (head.kind == CMD_ACK) ? CHR_A : head.csum;
        4'd8:       word.tx_byte = CHR_C;
        4'd9:       word.tx_byte = CHR_K;
        4'd10:      word.tx_byte = CHR_COLON;
        4'd11:      word.tx_byte = head.data;
        4'd12:      word.tx_byte = CHR_SEMI;
        default:    word.tx_byte = head.csum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= is_last ? 4'd0 : step_r + 4'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

[sv/packet_frame_builder_unit.sv]
// ----------------------------------------------------------------------------
// packet_frame_builder_unit
// Serializes outgoing frames with sync header and complement checksum.
// ----------------------------------------------------------------------------
// The block turns start, payload and ack items into a byte stream of frames:
// 0xAA 0xAA, id, destination, source, transmitter, length, payload, checksum,
// where the checksum is the complement of the low 8 bits of the sum of every
// byte after the sync pair. An item is taken in every cycle as long as the
// command queue between the front and the serializer has room (QUEUE_DEPTH
// entries), so payload bytes can stream at one per cycle. The output side
// delivers one word per cycle while out_ch.ready holds; an item gives one
// word for a rejection or a payload byte, two for the final payload byte,
// seven or eight for a start, and fourteen for an ack frame. The
// serializer's one word per cycle sets the sustained rate when long items
// follow one another; the queue absorbs short bursts. A rejected
// item (wrong order, length above MAX_PAYLOAD or an unused op code) gives a
// single zero word flagged rejected and last, and leaves all state alone.
// The device id register may only be written while the block is idle.
// ----------------------------------------------------------------------------
module packet_frame_builder_unit #(
  parameter int MAX_PAYLOAD = 50,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  pfb_in_if.sink     in_ch,
  pfb_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import pfb_pkg::*;

  // Commands flow from the front, through the queue, into the serializer.
  pfb_cmd_t cmd;
  pfb_cmd_t head;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     pop;

  // The front owns the ordering state, the id counter and the checksum sum,
  // so it never waits on the serializer except when the queue is full.
  pfb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .cmd       (cmd)
  );

  pfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  // The serializer pops a command once its final word is loaded into the
  // output register.
  pfb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

[sv/pfb_checker.sv]
// ----------------------------------------------------------------------------
// pfb_checker
// Port-level checks of the packet frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_frame_builder_unit_assert.svh"

module pfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_last,
  input logic       out_rejected
);

  logic [9:0] out_word;

  assign out_word = {out_tx_byte, out_last, out_rejected};

  // A stalled word stays on the port unchanged.
  `PFB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word))

  // A rejection is always a single zero word.
  `PFB_ASSERT(a_reject_word, clk, rst_n, out_valid && out_rejected |-> out_last && out_tx_byte == 8'h00)

  // Reset empties the queue and the output stage.
  `PFB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready)

endmodule

bind packet_frame_builder_unit pfb_checker u_pfb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_tx_byte  (out_ch.data.tx_byte),
  .out_last     (out_ch.data.last),
  .out_rejected (out_ch.data.rejected)
);
